// ===== hw/rtl/sitda_pkg.sv =====
// Shared types and constants for the signed integer to decimal text converter.
package sitda_pkg;

  // Field widths
  localparam int ValueWidth = 16;
  localparam int CharWidth  = 8;
  localparam int DigitWidth = 4;

  // Five decimal digits cover the 16-bit magnitude range
  localparam int MaxDigits  = 5;
  localparam int CountWidth = $clog2(MaxDigits + 1);

  // Divide by ten as multiply by reciprocal: exact for all 16-bit magnitudes
  localparam int RecipShift = 19;
  localparam int ProdWidth  = 2 * ValueWidth;
  localparam int QuotWidth  = ProdWidth - RecipShift;
  localparam logic [ValueWidth-1:0] RecipMul = 16'd52429;
  localparam logic [DigitWidth-1:0] DecBase  = 4'd10;

  // ASCII codes
  localparam logic [CharWidth-1:0] CharZero  = 8'h30;
  localparam logic [CharWidth-1:0] CharMinus = 8'h2D;

  // Controller to datapath commands
  typedef struct packed {
    logic load;      // take a new value, form magnitude
    logic step;      // extract one digit
    logic shift;     // drop the digit just sent
    logic sel_sign;  // present the minus sign on the output
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic quot_zero;   // the digit being extracted is the last one
    logic neg;         // value is negative
    logic last_digit;  // one digit left to send
  } status_t;

endpackage

// ===== hw/rtl/sitda_dpath.sv =====
// Datapath: magnitude register, divide-by-ten step and digit stack.
module sitda_dpath (
  input  logic                                  clk,
  input  logic                                  rst,
  input  sitda_pkg::cmd_t                       cmd,
  input  logic [sitda_pkg::ValueWidth-1:0]      value,
  output sitda_pkg::status_t                    status,
  output logic [sitda_pkg::CharWidth-1:0]       text_char,
  output logic                                  last
);

  logic [sitda_pkg::ValueWidth-1:0] mag;
  logic                             neg;
  logic [sitda_pkg::DigitWidth-1:0] digs [sitda_pkg::MaxDigits];
  logic [sitda_pkg::CountWidth-1:0] nd;

  logic [sitda_pkg::ProdWidth-1:0]  prod;
  logic [sitda_pkg::QuotWidth-1:0]  quot;
  logic [sitda_pkg::ValueWidth:0]   quot_ten;
  logic [sitda_pkg::ValueWidth:0]   diff;
  logic [sitda_pkg::DigitWidth-1:0] rem;

  // Quotient and remainder of the current magnitude by ten
  assign prod     = {{sitda_pkg::ValueWidth{1'b0}}, mag}
                  * {{sitda_pkg::ValueWidth{1'b0}}, sitda_pkg::RecipMul};
  assign quot     = prod[sitda_pkg::ProdWidth-1:sitda_pkg::RecipShift];
  assign quot_ten = ({{(sitda_pkg::ValueWidth+1-sitda_pkg::QuotWidth){1'b0}}, quot} << 3)
                  + ({{(sitda_pkg::ValueWidth+1-sitda_pkg::QuotWidth){1'b0}}, quot} << 1);
  assign diff     = {1'b0, mag} - quot_ten;
  assign rem      = diff[sitda_pkg::DigitWidth-1:0];

  // Magnitude and sign; 0 - 0x8000 wraps to 32768 as wanted
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      neg <= value[sitda_pkg::ValueWidth-1];
      mag <= value[sitda_pkg::ValueWidth-1] ? (sitda_pkg::ValueWidth'(0) - value) : value;
    end else if (cmd.step) begin
      mag <= sitda_pkg::ValueWidth'(quot);
    end
  end

  // Digit stack: entry 0 always holds the most significant digit so far
  always_ff @(posedge clk) begin
    if (cmd.step) begin
      digs[0] <= rem;
      for (int i = 1; i < sitda_pkg::MaxDigits; i++) begin
        digs[i] <= digs[i-1];
      end
    end else if (cmd.shift) begin
      for (int i = 0; i < sitda_pkg::MaxDigits - 1; i++) begin
        digs[i] <= digs[i+1];
      end
      digs[sitda_pkg::MaxDigits-1] <= '0;
    end
  end

  // Digit count
  always_ff @(posedge clk) begin
    if (rst) begin
      nd <= '0;
    end else if (cmd.load) begin
      nd <= '0;
    end else if (cmd.step) begin
      nd <= nd + 1'b1;
    end else if (cmd.shift) begin
      nd <= nd - 1'b1;
    end
  end

  assign status.quot_zero  = (quot == '0);
  assign status.neg        = neg;
  assign status.last_digit = (nd == sitda_pkg::CountWidth'(1));

  // Output character
  assign text_char = cmd.sel_sign ? sitda_pkg::CharMinus
                                  : (sitda_pkg::CharZero + sitda_pkg::CharWidth'(digs[0]));
  assign last      = !cmd.sel_sign && status.last_digit;

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    nd <= sitda_pkg::CountWidth'(sitda_pkg::MaxDigits))
    else $error("digit count beyond five");

  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    cmd.step |-> (diff < {{(sitda_pkg::ValueWidth+1-sitda_pkg::DigitWidth){1'b0}},
                          sitda_pkg::DecBase}))
    else $error("remainder not a decimal digit");

  a_shift_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.shift |-> (nd != '0))
    else $error("digit sent from an empty stack");
`endif

endmodule

// ===== hw/rtl/sitda_ctrl.sv =====
// Controller: sequences load, digit extraction and character output.
module sitda_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  output logic               m_tvalid,
  input  logic               m_tready,
  input  sitda_pkg::status_t status,
  output sitda_pkg::cmd_t    cmd
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StConv = 2'd1;
  localparam logic [1:0] StSign = 2'd2;
  localparam logic [1:0] StEmit = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  // Next state and commands
  always_comb begin
    state_next   = state;
    s_tready     = 1'b0;
    m_tvalid     = 1'b0;
    cmd          = '0;
    case (state)
      StIdle: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = StConv;
        end
      end
      StConv: begin
        cmd.step = 1'b1;
        if (status.quot_zero) begin
          state_next = status.neg ? StSign : StEmit;
        end
      end
      StSign: begin
        m_tvalid     = 1'b1;
        cmd.sel_sign = 1'b1;
        if (m_tready) begin
          state_next = StEmit;
        end
      end
      StEmit: begin
        m_tvalid = 1'b1;
        if (m_tready) begin
          cmd.shift = 1'b1;
          if (status.last_digit) begin
            state_next = StIdle;
          end
        end
      end
      default: begin
        state_next = StIdle;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= StIdle;
    end else begin
      state <= state_next;
    end
  end

`ifndef SYNTHESIS
  a_sign_only_neg: assert property (@(posedge clk) disable iff (rst)
    (state == StSign) |-> status.neg)
    else $error("minus sign sent for a non-negative value");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (s_tready && m_tvalid) == 1'b0)
    else $error("input taken while a character is pending");

  a_load_then_conv: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> (state == StConv))
    else $error("load not followed by conversion");
`endif

endmodule

// ===== hw/rtl/signed_int_to_decimal_ascii_core.sv =====
// Top level: signed 16-bit integer to decimal ASCII character stream.
//
// Input channel s_*: one beat per number; s_tdata[15:0] is the signed value.
// Output channel m_*: one beat per character, most significant first;
// m_tdata[7:0] is the ASCII code ('-' or '0'..'9'), m_tlast marks the final
// character of the number. Zero gives "0"; -32768 gives "-32768".
// One number is handled at a time: s_tready is high only while idle.
// Per number: the value is loaded at the accepting edge, then each decimal
// digit (1 to 5) is extracted in turn on the shared divide-by-ten unit, then
// each character (1 to 6) is sent as the receiver is ready, and a new number
// can be taken in the cycle after the last beat.
// The digit stack in the datapath sets the rate: characters are sent only
// once every digit has been extracted.
// Reset (rst, synchronous) returns the controller to idle and drops any
// number in progress. When m_tready is low the pending character and
// m_tlast hold steady and no input is taken.
module signed_int_to_decimal_ascii_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [15:0] value
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] text_char
  output logic        m_tlast
);

  sitda_pkg::cmd_t    cmd;
  sitda_pkg::status_t status;

  sitda_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  sitda_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .value     (s_tdata),
    .status    (status),
    .text_char (m_tdata),
    .last      (m_tlast)
  );

endmodule
